@@ rtl/skyatl_pkg.sv @@
// ----------------------------------------------------------------------------
// skyatl_pkg: shared types and defaults of the skyline atlas allocator
// Holds the request and response payload structs and the default geometry.
// ----------------------------------------------------------------------------
package skyatl_pkg;

   // Default atlas geometry
   localparam int COLUMNS_DEF  = 128;
   localparam int ROWS_DEF     = 128;
   localparam int PAGES_DEF    = 1;
   localparam int HEIGHT_W_DEF = 8;

   // Request transaction: rectangle size
   typedef struct packed {
      logic [6:0] rect_width;
      logic [7:0] rect_height;
   } req_type;

   // Response transaction: placement result
   typedef struct packed {
      logic       placed;
      logic [2:0] page_index;
      logic [6:0] pos_x;
      logic [6:0] pos_y;
   } rsp_type;

endpackage

@@ rtl/skyatl_ram.sv @@
// ----------------------------------------------------------------------------
// skyatl_ram: simple dual-port synchronous RAM
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
module skyatl_ram #(
   parameter int DEPTH = skyatl_pkg::COLUMNS_DEF,
   parameter int WIDTH = skyatl_pkg::HEIGHT_W_DEF
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read port
   always_ff @(posedge clock) begin
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/skyline_atlas_allocator.sv @@
// ----------------------------------------------------------------------------
// skyline_atlas_allocator: skyline rectangle packer for square atlas pages
// Keeps one fill height per column per page in a RAM and places each
// requested rectangle in the lowest, leftmost window of a page that fits.
// ----------------------------------------------------------------------------
// Usage:
//   req_valid/req_ready/req_data carry one rectangle size per transaction;
//   rsp_valid/rsp_ready/rsp_data return exactly one placement result for it.
//   After reset the height RAM is swept to zero, one entry per cycle, over
//   all COLUMNS*PAGES entries; req_ready stays low during that sweep.
//   One request is worked on at a time. Each page tried takes two passes:
//   a forward pass over the height RAM builds block prefix maxima in
//   a scratch RAM, a backward pass forms suffix maxima and window tops (one
//   column per cycle, set by the single read port of the height RAM).
//   A successful placement then writes rect_width columns, one per cycle.
//   A zero or out-of-range width skips the scan, and when no page fits every
//   page is tried before the result is given.
//   The result sits in an output register, so a stalled receiver only holds
//   that register; a new request is accepted while the result waits, and
//   the following result waits until the register is taken.
// ----------------------------------------------------------------------------
module skyline_atlas_allocator #(
   parameter int COLUMNS = skyatl_pkg::COLUMNS_DEF,
   parameter int ROWS    = skyatl_pkg::ROWS_DEF,
   parameter int PAGES   = skyatl_pkg::PAGES_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  skyatl_pkg::req_type req_data,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output skyatl_pkg::rsp_type rsp_data
);

   localparam int COL_W    = $clog2(COLUMNS);
   localparam int HADDR_W  = $clog2(COLUMNS * PAGES);
   localparam int HT_W     = $clog2(ROWS + 1);
   localparam int SUM_W    = ((HT_W > 8) ? HT_W : 8) + 1;
   localparam int EXT_W    = ((COL_W > 7) ? COL_W : 7) + 1;
   localparam int PG_W     = (PAGES > 1) ? $clog2(PAGES) : 1;
   localparam int LAST_COL = COLUMNS - 2;
   localparam int LAST_ENT = COLUMNS * PAGES - 1;

   localparam logic [2:0] S_CLEAR = 3'd0;
   localparam logic [2:0] S_IDLE  = 3'd1;
   localparam logic [2:0] S_FWD   = 3'd2;
   localparam logic [2:0] S_BWD   = 3'd3;
   localparam logic [2:0] S_WRITE = 3'd4;
   localparam logic [2:0] S_RESP  = 3'd5;

   // Control registers
   logic [2:0]          state_ff, state_in;
   logic [HADDR_W-1:0]  clr_ff, clr_in;
   logic                issue_ff, issue_in;
   logic                rd_vld_ff, rd_vld_in;
   logic                rsp_valid_ff, rsp_valid_in;

   // Working registers
   logic [6:0]          w_ff, w_in;
   logic [7:0]          h_ff, h_in;
   logic [PG_W-1:0]     page_ff, page_in;
   logic [HADDR_W-1:0]  base_ff, base_in;
   logic [COL_W-1:0]    col_ff, col_in;
   logic [COL_W-1:0]    rd_col_ff, rd_col_in;
   logic [6:0]          blk_ff, blk_in;
   logic [6:0]          wcnt_ff, wcnt_in;
   logic [HT_W-1:0]     g_ff, g_in;
   logic [HT_W-1:0]     s_ff, s_in;
   logic [HT_W-1:0]     best_ff, best_in;
   logic [COL_W-1:0]    bx_ff, bx_in;
   skyatl_pkg::rsp_type res_ff, res_in;
   skyatl_pkg::rsp_type rsp_data_ff, rsp_data_in;

   // RAM ports
   logic                hmem_we;
   logic [HADDR_W-1:0]  hmem_waddr;
   logic [HT_W-1:0]     hmem_wdata;
   logic [HADDR_W-1:0]  hmem_raddr;
   logic [HT_W-1:0]     hmem_rdata;
   logic                smem_we;
   logic [COL_W-1:0]    smem_raddr;
   logic [HT_W-1:0]     smem_rdata;

   // Datapath
   logic                blk_last;
   logic [HT_W-1:0]     g_new;
   logic [HT_W-1:0]     s_new;
   logic [HT_W-1:0]     top;
   logic                win_ok;
   logic                take_win;
   logic [HT_W-1:0]     best_nx;
   logic [COL_W-1:0]    bx_nx;
   logic [SUM_W-1:0]    fit_sum;
   logic                fits;
   logic                load_out;

   // Column fill heights of all pages
   skyatl_ram #(
      .DEPTH (COLUMNS * PAGES),
      .WIDTH (HT_W)
   ) u_hmem (
      .clock   (clock),
      .wr_en   (hmem_we),
      .wr_addr (hmem_waddr),
      .wr_data (hmem_wdata),
      .rd_addr (hmem_raddr),
      .rd_data (hmem_rdata)
   );

   // Block prefix maxima of the page being scanned
   skyatl_ram #(
      .DEPTH (COLUMNS),
      .WIDTH (HT_W)
   ) u_smem (
      .clock   (clock),
      .wr_en   (smem_we),
      .wr_addr (rd_col_ff),
      .wr_data (g_new),
      .rd_addr (smem_raddr),
      .rd_data (smem_rdata)
   );

   // Read addresses follow the column counter
   assign hmem_raddr = base_ff + HADDR_W'(col_ff);
   assign smem_raddr = COL_W'(EXT_W'(col_ff) + EXT_W'(w_ff) - EXT_W'(1));

   // Running maxima over blocks of rect_width columns
   assign blk_last = (blk_ff == (w_ff - 7'd1));
   assign g_new    = ((blk_ff == 7'd0) || (hmem_rdata > g_ff)) ? hmem_rdata : g_ff;
   assign s_new    = (blk_last || (hmem_rdata > s_ff)) ? hmem_rdata : s_ff;
   assign top      = (smem_rdata > s_new) ? smem_rdata : s_new;

   // Window choice: scanning right to left, ties move to the left
   assign win_ok   = (EXT_W'(rd_col_ff) + EXT_W'(w_ff)) < EXT_W'(COLUMNS);
   assign take_win = rd_vld_ff && win_ok && (top < HT_W'(ROWS)) && (top <= best_ff);
   assign best_nx  = take_win ? top : best_ff;
   assign bx_nx    = take_win ? rd_col_ff : bx_ff;
   assign fit_sum  = SUM_W'(best_nx) + SUM_W'(h_ff);
   assign fits     = (best_nx < HT_W'(ROWS)) && (fit_sum <= SUM_W'(ROWS));

   // Sequencer
   always_comb begin
      state_in   = state_ff;
      clr_in     = clr_ff;
      issue_in   = issue_ff;
      rd_vld_in  = 1'b0;
      rd_col_in  = col_ff;
      w_in       = w_ff;
      h_in       = h_ff;
      page_in    = page_ff;
      base_in    = base_ff;
      col_in     = col_ff;
      blk_in     = blk_ff;
      wcnt_in    = wcnt_ff;
      g_in       = g_ff;
      s_in       = s_ff;
      best_in    = best_ff;
      bx_in      = bx_ff;
      res_in     = res_ff;
      hmem_we    = 1'b0;
      hmem_waddr = clr_ff;
      hmem_wdata = '0;
      smem_we    = 1'b0;
      load_out   = 1'b0;
      case (state_ff)
         S_CLEAR: begin
            // Sweep the height RAM to zero
            hmem_we = 1'b1;
            clr_in  = clr_ff + HADDR_W'(1);
            if (clr_ff == HADDR_W'(LAST_ENT)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_valid) begin
               w_in    = req_data.rect_width;
               h_in    = req_data.rect_height;
               page_in = '0;
               base_in = '0;
               if ((req_data.rect_width == 7'd0) ||
                   (EXT_W'(req_data.rect_width) >= EXT_W'(COLUMNS))) begin
                  res_in   = '0;
                  state_in = S_RESP;
               end else begin
                  col_in   = '0;
                  issue_in = 1'b1;
                  blk_in   = 7'd0;
                  g_in     = '0;
                  state_in = S_FWD;
               end
            end
         end
         S_FWD: begin
            // Stream columns left to right
            if (issue_ff) begin
               rd_vld_in = 1'b1;
               if (col_ff == COL_W'(LAST_COL)) begin
                  issue_in = 1'b0;
               end else begin
                  col_in = col_ff + COL_W'(1);
               end
            end
            // Store block prefix maxima
            if (rd_vld_ff) begin
               smem_we = 1'b1;
               g_in    = g_new;
               if (rd_col_ff == COL_W'(LAST_COL)) begin
                  // Hold the block position of the last column for the way back
                  col_in   = COL_W'(LAST_COL);
                  issue_in = 1'b1;
                  s_in     = '0;
                  best_in  = HT_W'(ROWS);
                  bx_in    = '0;
                  state_in = S_BWD;
               end else begin
                  blk_in = blk_last ? 7'd0 : (blk_ff + 7'd1);
               end
            end
         end
         S_BWD: begin
            // Stream columns right to left
            if (issue_ff) begin
               rd_vld_in = 1'b1;
               if (col_ff == '0) begin
                  issue_in = 1'b0;
               end else begin
                  col_in = col_ff - COL_W'(1);
               end
            end
            // Combine suffix and prefix maxima into window tops
            if (rd_vld_ff) begin
               s_in    = s_new;
               blk_in  = (blk_ff == 7'd0) ? (w_ff - 7'd1) : (blk_ff - 7'd1);
               best_in = best_nx;
               bx_in   = bx_nx;
               if (rd_col_ff == '0) begin
                  if (fits) begin
                     col_in   = bx_nx;
                     wcnt_in  = w_ff;
                     state_in = S_WRITE;
                  end else if (page_ff == PG_W'(PAGES - 1)) begin
                     res_in   = '0;
                     state_in = S_RESP;
                  end else begin
                     // Advance to the next page
                     page_in  = page_ff + PG_W'(1);
                     base_in  = base_ff + HADDR_W'(COLUMNS);
                     col_in   = '0;
                     issue_in = 1'b1;
                     blk_in   = 7'd0;
                     g_in     = '0;
                     state_in = S_FWD;
                  end
               end
            end
         end
         S_WRITE: begin
            // Raise the chosen window
            hmem_we    = 1'b1;
            hmem_waddr = hmem_raddr;
            hmem_wdata = HT_W'(fit_sum);
            col_in     = col_ff + COL_W'(1);
            wcnt_in    = wcnt_ff - 7'd1;
            if (wcnt_ff == 7'd1) begin
               res_in.placed     = 1'b1;
               res_in.page_index = 3'(page_ff);
               res_in.pos_x      = 7'(bx_ff);
               res_in.pos_y      = 7'(best_ff);
               state_in          = S_RESP;
            end
         end
         S_RESP: begin
            if (!rsp_valid_ff || rsp_ready) begin
               load_out = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // fit_sum during the write phase uses the held best height
   // (best_nx equals best_ff there because no read is in flight)

   // Output register
   assign rsp_valid_in = load_out || (rsp_valid_ff && !rsp_ready);
   assign rsp_data_in  = load_out ? res_ff : rsp_data_ff;

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         issue_ff     <= 1'b0;
         rd_vld_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         issue_ff     <= issue_in;
         rd_vld_ff    <= rd_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Working state
   always_ff @(posedge clock) begin
      rd_col_ff   <= rd_col_in;
      w_ff        <= w_in;
      h_ff        <= h_in;
      page_ff     <= page_in;
      base_ff     <= base_in;
      col_ff      <= col_in;
      blk_ff      <= blk_in;
      wcnt_ff     <= wcnt_in;
      g_ff        <= g_in;
      s_ff        <= s_in;
      best_ff     <= best_in;
      bx_ff       <= bx_in;
      res_ff      <= res_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

`ifndef SYNTHESIS
   // No RAM read may still be in flight once the block is idle
   a_idle_no_read: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE) |-> !rd_vld_ff)
      else $error("read pending while idle");

   // Block position stays inside the current width while a scan read is valid
   a_blk_range: assert property (@(posedge clock) disable iff (reset)
      (rd_vld_ff && ((state_ff == S_FWD) || (state_ff == S_BWD))) |-> (blk_ff < w_ff))
      else $error("block position out of range");

   // A written window height never exceeds the page
   a_write_fits: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_WRITE) |-> ((best_ff < HT_W'(ROWS)) && (fit_sum <= SUM_W'(ROWS))))
      else $error("window raised above page");

   // A result is loaded only when the output register is free or drained
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ready && (state_ff == S_RESP)) |=> (state_ff == S_RESP))
      else $error("result dropped while receiver stalls");
`endif

endmodule

@@ tb/sv/tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: self-checking testbench for skyline_atlas_allocator
// Drives rectangle requests through the valid/ready request channel, tracks
// the expected per-column fill heights in a local skyline, and compares every
// placement transaction field by field. Covers field extremes, failing sizes,
// zero heights, a long result stall and a page filled in every reachable column.
// ----------------------------------------------------------------------------
module tb;

   localparam int NUM_COLS         = skyatl_pkg::COLUMNS_DEF;
   localparam int NUM_ROWS         = skyatl_pkg::ROWS_DEF;
   localparam int NUM_PAGES        = skyatl_pkg::PAGES_DEF;
   localparam int RESET_CYCLES     = 10;
   localparam int LONG_HOLD_CYCLES = 3000;
   localparam int DRAIN_CYCLES     = 2 * (2 * NUM_COLS * NUM_PAGES + NUM_COLS);
   localparam int CYCLE_LIMIT      = 2_000_000;

   logic                clock     = 1'b0;
   logic                reset     = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_ready;
   skyatl_pkg::req_type req_data  = '0;
   logic                rsp_valid;
   logic                rsp_ready = 1'b0;
   skyatl_pkg::rsp_type rsp_data;

   // Expected fill height of every column on every page
   int unsigned         skyline_fill [NUM_PAGES][NUM_COLS];
   // Placements predicted for accepted requests, oldest first
   skyatl_pkg::rsp_type expected_placements [$];

   int error_count       = 0;
   bit quiet_phase       = 1'b0;
   bit long_hold_pending = 1'b0;

   skyline_atlas_allocator #(
      .COLUMNS(NUM_COLS),
      .ROWS   (NUM_ROWS),
      .PAGES  (NUM_PAGES)
   ) uut (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data (rsp_data)
   );

   // 12 ns clock
   initial begin
      forever #6 clock = ~clock;
   end

   // Guard against a hung run
   initial begin : watchdog
      repeat (CYCLE_LIMIT) @(posedge clock);
      $display("skyline_atlas_allocator verification failed");
      $finish;
   end

   // Place one rectangle in the local skyline and return the expected result
   function automatic skyatl_pkg::rsp_type place_rect(input skyatl_pkg::req_type rq);
      skyatl_pkg::rsp_type res;
      int unsigned         w;
      int unsigned         h;
      int unsigned         best;
      int unsigned         best_x;
      int unsigned         top;
      int unsigned         pg;
      int unsigned         i;
      int unsigned         j;
      bit                  found;
      res = '0;
      w   = 32'(rq.rect_width);
      h   = 32'(rq.rect_height);
      if (w == 0 || w >= NUM_COLS) begin
         return res;
      end
      for (pg = 0; pg < NUM_PAGES; pg++) begin
         best   = NUM_ROWS;
         best_x = 0;
         found  = 1'b0;
         // scan start columns; the rightmost possible one is left out
         for (i = 0; i + w < NUM_COLS; i++) begin
            top = 0;
            for (j = 0; j < w; j++) begin
               if (skyline_fill[pg][i + j] > top) begin
                  top = skyline_fill[pg][i + j];
               end
            end
            if (top < best) begin
               best   = top;
               best_x = i;
               found  = 1'b1;
            end
         end
         if (!found || best + h > NUM_ROWS) begin
            continue;
         end
         // raise the chosen window
         for (j = 0; j < w; j++) begin
            skyline_fill[pg][best_x + j] = best + h;
         end
         res.placed     = 1'b1;
         res.page_index = pg[2:0];
         res.pos_x      = best_x[6:0];
         res.pos_y      = best[6:0];
         return res;
      end
      return res;
   endfunction

   // Offer one request and wait until it is taken; called and returning at a falling edge
   task automatic send_rect(input logic [6:0] w, input logic [7:0] h);
      skyatl_pkg::req_type item;
      int                  gap;
      item.rect_width  = w;
      item.rect_height = h;
      // idle the request channel for a short burst now and then
      if (!quiet_phase && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 5);
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_data  <= item;
      req_valid <= 1'b1;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      expected_placements.push_back(place_rect(item));
      @(negedge clock);
   endtask

   // Draw one request from a mix weighted toward placements that fit
   task automatic send_random_rect();
      int unsigned pick;
      logic [6:0]  w;
      logic [7:0]  h;
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
         w = 7'($urandom_range(1, 8));
         h = 8'($urandom_range(0, 3));
      end else if (pick < 70) begin
         w = 7'($urandom_range(9, 127));
         h = ($urandom_range(0, 3) == 0) ? 8'd1 : 8'd0;
      end else if (pick < 80) begin
         w = 7'($urandom_range(0, 127));
         h = 8'($urandom_range(NUM_ROWS + 1, 255));
      end else if (pick < 88) begin
         w = 7'd0;
         h = 8'($urandom_range(0, 255));
      end else begin
         w = 7'($urandom_range(1, 32));
         h = 8'($urandom_range(0, 6));
      end
      send_rect(w, h);
   endtask

   // Drop valid and wait until every expected placement has come back
   task automatic wait_placements_done();
      req_valid <= 1'b0;
      @(negedge clock);
      while (expected_placements.size() != 0) @(negedge clock);
   endtask

   task automatic check_field(input string name, input logic [7:0] exp_v,
                              input logic [7:0] act_v);
      if (exp_v !== act_v) begin
         $error("placement mismatch on %s: expected %0d, got %0d", name, exp_v, act_v);
         error_count++;
      end
   endtask

   // Compare each accepted result transaction with the oldest prediction
   always @(posedge clock) begin : result_check
      skyatl_pkg::rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_placements.size() == 0) begin
            $error("unexpected result transaction: placed %0d page %0d x %0d y %0d",
                   rsp_data.placed, rsp_data.page_index, rsp_data.pos_x, rsp_data.pos_y);
            error_count++;
         end else begin
            want = expected_placements.pop_front();
            check_field("placed", 8'(want.placed), 8'(rsp_data.placed));
            check_field("page_index", 8'(want.page_index), 8'(rsp_data.page_index));
            check_field("pos_x", 8'(want.pos_x), 8'(rsp_data.pos_x));
            check_field("pos_y", 8'(want.pos_y), 8'(rsp_data.pos_y));
         end
      end
   end

   // Result receiver: random stall bursts, plus one long hold on request
   initial begin : result_sink
      int idle_left;
      idle_left = 0;
      forever begin
         @(negedge clock);
         if (long_hold_pending) begin
            rsp_ready <= 1'b0;
            repeat (LONG_HOLD_CYCLES) @(negedge clock);
            long_hold_pending = 1'b0;
            rsp_ready <= 1'b1;
         end else if (idle_left > 0) begin
            rsp_ready <= 1'b0;
            idle_left--;
         end else if (!quiet_phase && $urandom_range(0, 7) == 0) begin
            idle_left = int'($urandom_range(1, 5)) - 1;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // Field extremes, zero width, zero height and heights above the page
   task automatic test_directed_extremes();
      send_rect(7'd0, 8'd0);
      send_rect(7'd0, 8'd255);
      send_rect(7'd1, 8'd0);
      send_rect(7'd1, 8'd1);
      send_rect(7'd127, 8'd0);
      send_rect(7'd127, 8'd200);
      send_rect(7'd127, 8'd129);
      send_rect(7'd2, 8'd5);
      send_rect(7'd64, 8'd3);
      send_rect(7'd126, 8'd0);
      send_rect(7'd1, 8'd128);
      send_rect(7'd8, 8'd127);
      send_rect(7'd100, 8'd1);
      send_rect(7'd127, 8'd255);
      send_rect(7'd3, 8'd0);
      send_rect(7'd5, 8'd130);
      wait_placements_done();
   endtask

   // Hold the receiver off for a long stretch while requests keep coming
   task automatic test_result_backpressure();
      int n;
      long_hold_pending = 1'b1;
      for (n = 0; n < 8; n++) begin
         send_rect(7'($urandom_range(1, 6)), 8'($urandom_range(0, 2)));
      end
      wait_placements_done();
   endtask

   task automatic test_random_with_idling();
      int n;
      for (n = 0; n < 900; n++) begin
         send_random_rect();
      end
      wait_placements_done();
   endtask

   // Back-to-back traffic, no idling on either side
   task automatic test_random_back_to_back();
      int n;
      quiet_phase = 1'b1;
      @(negedge clock);
      for (n = 0; n < 230; n++) begin
         send_random_rect();
      end
      wait_placements_done();
   endtask

   // Fill the reachable columns of the first page to the top, then probe it
   task automatic test_full_page();
      int unsigned top;
      int          c;
      int          n;
      top = 0;
      for (c = 0; c < NUM_COLS - 1; c++) begin
         if (skyline_fill[0][c] > top) begin
            top = skyline_fill[0][c];
         end
      end
      if (top < NUM_ROWS) begin
         send_rect(7'd127, 8'(NUM_ROWS - top));
      end
      send_rect(7'd1, 8'd0);
      send_rect(7'd1, 8'd1);
      send_rect(7'd127, 8'd0);
      send_rect(7'd64, 8'd64);
      send_rect(7'd0, 8'd5);
      for (n = 0; n < 6; n++) begin
         send_rect(7'($urandom_range(1, 127)), 8'($urandom_range(0, NUM_ROWS)));
      end
      wait_placements_done();
   endtask

   initial begin : test_sequence
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_directed_extremes();
      test_result_backpressure();
      test_random_with_idling();
      test_random_back_to_back();
      test_full_page();
      // let any stray result show up
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (error_count == 0 && expected_placements.size() == 0) begin
         $display("skyline_atlas_allocator verification clean");
      end else begin
         $display("skyline_atlas_allocator verification failed");
      end
      $finish;
   end

endmodule
